>>> rtl/ostt_pkg.sv
// Shared constants and types of the ordered software timer table.
// Used by the channel interfaces, the table cells and the top level.
`default_nettype none
package ostt_pkg;

   localparam int ID_BITS    = 31;
   localparam int OP_BITS    = 3;
   localparam int KIND_BITS  = 2;
   localparam int DELAY_BITS = 32;
   localparam int LIMIT_BITS = 32;

   localparam logic [OP_BITS-1:0] OP_ADD_ONCE    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ADD_PERIOD  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_ADD_IDLE    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_CANCEL_ID   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CANCEL_OWNER = 3'd4;
   localparam logic [OP_BITS-1:0] OP_TICK        = 3'd5;
   localparam logic [OP_BITS-1:0] OP_CLEAR       = 3'd6;

   localparam logic [KIND_BITS-1:0] KIND_ASSIGNED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRED    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DONE     = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_FULL     = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ADD,
      CMD_CANCEL_ID,
      CMD_CANCEL_OWNER,
      CMD_CLEAR,
      CMD_MARK,
      CMD_SELECT,
      CMD_FIRE,
      CMD_ADVANCE
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    add_repeat;
      logic    add_idle;
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/ostt_req_if.sv
// Request channel of the ordered software timer table.
// Depends on ostt_pkg for field widths.
`default_nettype none
interface ostt_req_if #(
   parameter int TIME_BITS  = 48,
   parameter int OWNER_BITS = 8
);
   logic                                   valid;
   logic                                   ready;
   logic [ostt_pkg::OP_BITS-1:0]           operation;
   logic [TIME_BITS-1:0]                   now_time;
   logic signed [ostt_pkg::DELAY_BITS-1:0] delay_time;
   logic [ostt_pkg::LIMIT_BITS-1:0]        idle_limit;
   logic [ostt_pkg::ID_BITS-1:0]           cancel_id;
   logic [OWNER_BITS-1:0]                  owner_tag;

   modport source (output valid, operation, now_time, delay_time, idle_limit, cancel_id,
                   owner_tag, input ready);
   modport sink (input valid, operation, now_time, delay_time, idle_limit, cancel_id,
                 owner_tag, output ready);
endinterface
`default_nettype wire

>>> rtl/ostt_rsp_if.sv
// Result channel of the ordered software timer table.
// Depends on ostt_pkg for field widths.
`default_nettype none
interface ostt_rsp_if #(
   parameter int OWNER_BITS = 8
);
   logic                            valid;
   logic                            ready;
   logic [ostt_pkg::KIND_BITS-1:0]  result_kind;
   logic [ostt_pkg::ID_BITS-1:0]    timer_id;
   logic [OWNER_BITS-1:0]           fired_owner;
   logic                            is_idle;
   logic                            did_timeout;
   logic                            last;

   modport source (output valid, result_kind, timer_id, fired_owner, is_idle, did_timeout,
                   last, input ready);
   modport sink (input valid, result_kind, timer_id, fired_owner, is_idle, did_timeout,
                 last, output ready);
endinterface
`default_nettype wire

>>> rtl/ordered_software_timer_table_unit.sv
// Top level of the ordered software timer table: sequencer, result register
// and the chain of entry cells. Depends on ostt_pkg, the channel interfaces and ostt_cell.
//
// Each request word on req_ch is one operation: add a one-shot, periodic or idle
// timer, cancel by id or by owner, clear all, or tick. Every operation sends a
// probe word down the chain of TABLE_DEPTH cells, one cell per cycle, and adds,
// cancels and clears give their single result word once the probe leaves the
// chain. A tick marks the due entries in one pass and then runs one ordering
// pass per due entry, plus a last pass that finds none. One request is worked at
// a time; a new request is taken as soon as the final result word sits in the
// output register. When rsp_ch is stalled the block holds its results and
// waits, losing nothing. Reset empties the table and sets the next id to one;
// no clearing pass is needed.
`default_nettype none
module ordered_software_timer_table_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int TIME_BITS   = 48,
   parameter int OWNER_BITS  = 8
) (
   input wire         clock,
   input wire         reset,
   ostt_req_if.sink   req_ch,
   ostt_rsp_if.source rsp_ch
);

   localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
   localparam int IDW = ostt_pkg::ID_BITS;
   localparam logic [IDW-1:0] ID_MAX = '1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_WAVE = 6'b000010,
      ST_PUSH = 6'b000100,
      ST_FIRE = 6'b001000,
      ST_ADV  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   ostt_pkg::ctl_type               ctl_ff, ctl_in;
   logic                            start_ff, start_in;
   logic [TIME_BITS-1:0]            now_ff, now_in;
   logic [IDW-1:0]                  period_ff, period_in;
   logic [ostt_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [IDW-1:0]                  cid_ff, cid_in;
   logic [OWNER_BITS-1:0]           owner_ff, owner_in;
   logic [IDW-1:0]                  next_id_ff, next_id_in;
   logic [SLOT_BITS-1:0]            target_ff, target_in;

   logic [IDW-1:0]                  win_id_ff, win_id_in;
   logic [OWNER_BITS-1:0]           win_owner_ff, win_owner_in;
   logic                            win_idle_ff, win_idle_in;
   logic                            win_tmo_ff, win_tmo_in;

   logic                            pend_ff, pend_in;
   logic [IDW-1:0]                  pend_id_ff, pend_id_in;
   logic [OWNER_BITS-1:0]           pend_owner_ff, pend_owner_in;
   logic                            pend_idle_ff, pend_idle_in;
   logic                            pend_tmo_ff, pend_tmo_in;

   logic [ostt_pkg::KIND_BITS-1:0]  fin_kind_ff, fin_kind_in;
   logic [IDW-1:0]                  fin_id_ff, fin_id_in;
   logic [OWNER_BITS-1:0]           fin_owner_ff, fin_owner_in;
   logic                            fin_idle_ff, fin_idle_in;
   logic                            fin_tmo_ff, fin_tmo_in;

   logic                            out_valid_ff, out_valid_in;
   logic [ostt_pkg::KIND_BITS-1:0]  out_kind_ff, out_kind_in;
   logic [IDW-1:0]                  out_id_ff, out_id_in;
   logic [OWNER_BITS-1:0]           out_owner_ff, out_owner_in;
   logic                            out_idle_ff, out_idle_in;
   logic                            out_tmo_ff, out_tmo_in;
   logic                            out_last_ff, out_last_in;

   logic                            ch_tag   [TABLE_DEPTH+1];
   logic                            ch_hit   [TABLE_DEPTH+1];
   logic [TIME_BITS-1:0]            ch_dl    [TABLE_DEPTH+1];
   logic [IDW-1:0]                  ch_id    [TABLE_DEPTH+1];
   logic [OWNER_BITS-1:0]           ch_owner [TABLE_DEPTH+1];
   logic                            ch_idle  [TABLE_DEPTH+1];
   logic                            ch_tmo   [TABLE_DEPTH+1];
   logic [SLOT_BITS-1:0]            ch_slot  [TABLE_DEPTH+1];

   logic                            accept;

   assign ch_tag[0]   = start_ff;
   assign ch_hit[0]   = 1'b0;
   assign ch_dl[0]    = '0;
   assign ch_id[0]    = '0;
   assign ch_owner[0] = '0;
   assign ch_idle[0]  = 1'b0;
   assign ch_tmo[0]   = 1'b0;
   assign ch_slot[0]  = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ostt_cell #(
         .TIME_BITS (TIME_BITS),
         .OWNER_BITS(OWNER_BITS),
         .SLOT_BITS (SLOT_BITS),
         .SLOT_INDEX(g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl_ff),
         .target_slot(target_ff),
         .now_time   (now_ff),
         .add_period (period_ff),
         .add_limit  (limit_ff),
         .cancel_id  (cid_ff),
         .owner_tag  (owner_ff),
         .new_id     (next_id_ff),
         .up_tag     (ch_tag[g]),
         .up_hit     (ch_hit[g]),
         .up_deadline(ch_dl[g]),
         .up_id      (ch_id[g]),
         .up_owner   (ch_owner[g]),
         .up_idle    (ch_idle[g]),
         .up_tmo     (ch_tmo[g]),
         .up_slot    (ch_slot[g]),
         .dn_tag     (ch_tag[g+1]),
         .dn_hit     (ch_hit[g+1]),
         .dn_deadline(ch_dl[g+1]),
         .dn_id      (ch_id[g+1]),
         .dn_owner   (ch_owner[g+1]),
         .dn_idle    (ch_idle[g+1]),
         .dn_tmo     (ch_tmo[g+1]),
         .dn_slot    (ch_slot[g+1])
      );
   end

   assign req_ch.ready = state_ff == ST_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in      = state_ff;
      ctl_in        = ctl_ff;
      start_in      = 1'b0;
      now_in        = now_ff;
      period_in     = period_ff;
      limit_in      = limit_ff;
      cid_in        = cid_ff;
      owner_in      = owner_ff;
      next_id_in    = next_id_ff;
      target_in     = target_ff;
      win_id_in     = win_id_ff;
      win_owner_in  = win_owner_ff;
      win_idle_in   = win_idle_ff;
      win_tmo_in    = win_tmo_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      pend_owner_in = pend_owner_ff;
      pend_idle_in  = pend_idle_ff;
      pend_tmo_in   = pend_tmo_ff;
      fin_kind_in   = fin_kind_ff;
      fin_id_in     = fin_id_ff;
      fin_owner_in  = fin_owner_ff;
      fin_idle_in   = fin_idle_ff;
      fin_tmo_in    = fin_tmo_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_kind_in   = out_kind_ff;
      out_id_in     = out_id_ff;
      out_owner_in  = out_owner_ff;
      out_idle_in   = out_idle_ff;
      out_tmo_in    = out_tmo_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in    = req_ch.now_time;
               period_in = req_ch.delay_time[ostt_pkg::DELAY_BITS-1] ? '0
                                                                     : req_ch.delay_time[IDW-1:0];
               limit_in  = req_ch.idle_limit;
               cid_in    = req_ch.cancel_id;
               owner_in  = req_ch.owner_tag;
               pend_in   = 1'b0;
               ctl_in.add_repeat = req_ch.operation == ostt_pkg::OP_ADD_PERIOD;
               ctl_in.add_idle   = req_ch.operation == ostt_pkg::OP_ADD_IDLE;
               start_in  = 1'b1;
               state_in  = ST_WAVE;
               unique case (req_ch.operation)
                  ostt_pkg::OP_ADD_ONCE, ostt_pkg::OP_ADD_PERIOD, ostt_pkg::OP_ADD_IDLE:
                     ctl_in.cmd = ostt_pkg::CMD_ADD;
                  ostt_pkg::OP_CANCEL_ID:    ctl_in.cmd = ostt_pkg::CMD_CANCEL_ID;
                  ostt_pkg::OP_CANCEL_OWNER: ctl_in.cmd = ostt_pkg::CMD_CANCEL_OWNER;
                  ostt_pkg::OP_TICK:         ctl_in.cmd = ostt_pkg::CMD_MARK;
                  ostt_pkg::OP_CLEAR:        ctl_in.cmd = ostt_pkg::CMD_CLEAR;
                  default: begin
                     ctl_in.cmd  = ostt_pkg::CMD_NONE;
                     start_in    = 1'b0;
                     fin_kind_in = ostt_pkg::KIND_DONE;
                     fin_id_in   = '0;
                     fin_owner_in = '0;
                     fin_idle_in = 1'b0;
                     fin_tmo_in  = 1'b0;
                     state_in    = ST_EMIT;
                  end
               endcase
            end
         end
         ST_WAVE: begin
            if (ch_tag[TABLE_DEPTH]) begin
               fin_kind_in  = ostt_pkg::KIND_DONE;
               fin_id_in    = '0;
               fin_owner_in = '0;
               fin_idle_in  = 1'b0;
               fin_tmo_in   = 1'b0;
               ctl_in.cmd   = ostt_pkg::CMD_NONE;
               state_in     = ST_EMIT;
               unique case (ctl_ff.cmd)
                  ostt_pkg::CMD_ADD: begin
                     if (ch_hit[TABLE_DEPTH]) begin
                        fin_kind_in = ostt_pkg::KIND_ASSIGNED;
                        fin_id_in   = next_id_ff;
                        next_id_in  = (next_id_ff == ID_MAX) ? IDW'(1) : next_id_ff + IDW'(1);
                     end else begin
                        fin_kind_in = ostt_pkg::KIND_FULL;
                     end
                  end
                  ostt_pkg::CMD_MARK: begin
                     ctl_in.cmd = ostt_pkg::CMD_SELECT;
                     start_in   = 1'b1;
                     state_in   = ST_WAVE;
                  end
                  ostt_pkg::CMD_SELECT: begin
                     if (ch_hit[TABLE_DEPTH]) begin
                        win_id_in    = ch_id[TABLE_DEPTH];
                        win_owner_in = ch_owner[TABLE_DEPTH];
                        win_idle_in  = ch_idle[TABLE_DEPTH];
                        win_tmo_in   = ch_tmo[TABLE_DEPTH];
                        target_in    = ch_slot[TABLE_DEPTH];
                        state_in     = ST_PUSH;
                     end else if (pend_ff) begin
                        fin_kind_in  = ostt_pkg::KIND_FIRED;
                        fin_id_in    = pend_id_ff;
                        fin_owner_in = pend_owner_ff;
                        fin_idle_in  = pend_idle_ff;
                        fin_tmo_in   = pend_tmo_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (!pend_ff || !out_valid_ff) begin
               if (pend_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = ostt_pkg::KIND_FIRED;
                  out_id_in    = pend_id_ff;
                  out_owner_in = pend_owner_ff;
                  out_idle_in  = pend_idle_ff;
                  out_tmo_in   = pend_tmo_ff;
                  out_last_in  = 1'b0;
               end
               pend_in       = 1'b1;
               pend_id_in    = win_id_ff;
               pend_owner_in = win_owner_ff;
               pend_idle_in  = win_idle_ff;
               pend_tmo_in   = win_tmo_ff;
               ctl_in.cmd    = ostt_pkg::CMD_FIRE;
               state_in      = ST_FIRE;
            end
         end
         ST_FIRE: begin
            ctl_in.cmd = ostt_pkg::CMD_ADVANCE;
            state_in   = ST_ADV;
         end
         ST_ADV: begin
            ctl_in.cmd = ostt_pkg::CMD_SELECT;
            start_in   = 1'b1;
            state_in   = ST_WAVE;
         end
         ST_EMIT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_kind_in  = fin_kind_ff;
               out_id_in    = fin_id_ff;
               out_owner_in = fin_owner_ff;
               out_idle_in  = fin_idle_ff;
               out_tmo_in   = fin_tmo_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctl_ff       <= '{cmd: ostt_pkg::CMD_NONE, add_repeat: 1'b0, add_idle: 1'b0};
         start_ff     <= 1'b0;
         next_id_ff   <= IDW'(1);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctl_ff       <= ctl_in;
         start_ff     <= start_in;
         next_id_ff   <= next_id_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      now_ff        <= now_in;
      period_ff     <= period_in;
      limit_ff      <= limit_in;
      cid_ff        <= cid_in;
      owner_ff      <= owner_in;
      target_ff     <= target_in;
      win_id_ff     <= win_id_in;
      win_owner_ff  <= win_owner_in;
      win_idle_ff   <= win_idle_in;
      win_tmo_ff    <= win_tmo_in;
      pend_id_ff    <= pend_id_in;
      pend_owner_ff <= pend_owner_in;
      pend_idle_ff  <= pend_idle_in;
      pend_tmo_ff   <= pend_tmo_in;
      fin_kind_ff   <= fin_kind_in;
      fin_id_ff     <= fin_id_in;
      fin_owner_ff  <= fin_owner_in;
      fin_idle_ff   <= fin_idle_in;
      fin_tmo_ff    <= fin_tmo_in;
      out_kind_ff   <= out_kind_in;
      out_id_ff     <= out_id_in;
      out_owner_ff  <= out_owner_in;
      out_idle_ff   <= out_idle_in;
      out_tmo_ff    <= out_tmo_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result_kind = out_kind_ff;
   assign rsp_ch.timer_id    = out_id_ff;
   assign rsp_ch.fired_owner = out_owner_ff;
   assign rsp_ch.is_idle     = out_idle_ff;
   assign rsp_ch.did_timeout = out_tmo_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/ostt_cell.sv
// One timer entry of the table, with its stage of the search chain.
// Depends on ostt_pkg for the command struct.
`default_nettype none
module ostt_cell #(
   parameter int TIME_BITS  = 48,
   parameter int OWNER_BITS = 8,
   parameter int SLOT_BITS  = 5,
   parameter int SLOT_INDEX = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  ostt_pkg::ctl_type                    ctl,
   input  wire [SLOT_BITS-1:0]                  target_slot,
   input  wire [TIME_BITS-1:0]                  now_time,
   input  wire [ostt_pkg::ID_BITS-1:0]          add_period,
   input  wire [ostt_pkg::LIMIT_BITS-1:0]       add_limit,
   input  wire [ostt_pkg::ID_BITS-1:0]          cancel_id,
   input  wire [OWNER_BITS-1:0]                 owner_tag,
   input  wire [ostt_pkg::ID_BITS-1:0]          new_id,
   input  wire                                  up_tag,
   input  wire                                  up_hit,
   input  wire [TIME_BITS-1:0]                  up_deadline,
   input  wire [ostt_pkg::ID_BITS-1:0]          up_id,
   input  wire [OWNER_BITS-1:0]                 up_owner,
   input  wire                                  up_idle,
   input  wire                                  up_tmo,
   input  wire [SLOT_BITS-1:0]                  up_slot,
   output logic                                 dn_tag,
   output logic                                 dn_hit,
   output logic [TIME_BITS-1:0]                 dn_deadline,
   output logic [ostt_pkg::ID_BITS-1:0]         dn_id,
   output logic [OWNER_BITS-1:0]                dn_owner,
   output logic                                 dn_idle,
   output logic                                 dn_tmo,
   output logic [SLOT_BITS-1:0]                 dn_slot
);

   localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(SLOT_INDEX);

   logic                            valid_ff, valid_in;
   logic                            batch_ff, batch_in;
   logic                            tmo_ff, tmo_in;
   logic [ostt_pkg::ID_BITS-1:0]    id_ff, id_in;
   logic [TIME_BITS-1:0]            dl_ff, dl_in;
   logic [ostt_pkg::ID_BITS-1:0]    period_ff, period_in;
   logic                            repeat_ff, repeat_in;
   logic                            idle_ff, idle_in;
   logic [ostt_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [OWNER_BITS-1:0]           owner_ff, owner_in;

   logic                            dn_tag_ff, dn_tag_in;
   logic                            dn_hit_ff, dn_hit_in;
   logic [TIME_BITS-1:0]            dn_dl_ff, dn_dl_in;
   logic [ostt_pkg::ID_BITS-1:0]    dn_id_ff, dn_id_in;
   logic [OWNER_BITS-1:0]           dn_owner_ff, dn_owner_in;
   logic                            dn_idle_ff, dn_idle_in;
   logic                            dn_tmo_ff, dn_tmo_in;
   logic [SLOT_BITS-1:0]            dn_slot_ff, dn_slot_in;

   logic                            due;
   logic                            own_first;
   logic [TIME_BITS-1:0]            elapsed;
   logic [TIME_BITS-1:0]            step_dl;
   logic [TIME_BITS-1:0]            step_now;
   logic [TIME_BITS-1:0]            add_dl;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [ostt_pkg::ID_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + (TIME_BITS+1)'(b);
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

   assign due       = dl_ff <= now_time;
   assign elapsed   = now_time - dl_ff;
   assign own_first = {dl_ff, id_ff} < {up_deadline, up_id};
   assign step_dl   = sat_add(dl_ff, period_ff);
   assign step_now  = sat_add(now_time, period_ff);
   assign add_dl    = sat_add(now_time, add_period);

   always_comb begin
      valid_in    = valid_ff;
      batch_in    = batch_ff;
      tmo_in      = tmo_ff;
      id_in       = id_ff;
      dl_in       = dl_ff;
      period_in   = period_ff;
      repeat_in   = repeat_ff;
      idle_in     = idle_ff;
      limit_in    = limit_ff;
      owner_in    = owner_ff;
      dn_tag_in   = up_tag;
      dn_hit_in   = up_hit;
      dn_dl_in    = up_deadline;
      dn_id_in    = up_id;
      dn_owner_in = up_owner;
      dn_idle_in  = up_idle;
      dn_tmo_in   = up_tmo;
      dn_slot_in  = up_slot;
      unique case (ctl.cmd)
         ostt_pkg::CMD_ADD: begin
            if (up_tag && !up_hit && !valid_ff) begin
               valid_in  = 1'b1;
               batch_in  = 1'b0;
               id_in     = new_id;
               owner_in  = owner_tag;
               repeat_in = ctl.add_repeat;
               idle_in   = ctl.add_idle;
               dl_in     = ctl.add_idle ? now_time : add_dl;
               period_in = ctl.add_idle ? '0 : add_period;
               limit_in  = ctl.add_idle ? add_limit : '0;
               dn_hit_in = 1'b1;
            end
         end
         ostt_pkg::CMD_CANCEL_ID: begin
            if (up_tag && !up_hit && valid_ff && id_ff == cancel_id) begin
               valid_in  = 1'b0;
               dn_hit_in = 1'b1;
            end
         end
         ostt_pkg::CMD_CANCEL_OWNER: begin
            if (up_tag && valid_ff && owner_ff == owner_tag) begin
               valid_in = 1'b0;
            end
         end
         ostt_pkg::CMD_CLEAR: begin
            if (up_tag) begin
               valid_in = 1'b0;
            end
         end
         ostt_pkg::CMD_MARK: begin
            if (up_tag) begin
               batch_in = valid_ff && due;
               tmo_in   = idle_ff && limit_ff != '0 && elapsed >= TIME_BITS'(limit_ff);
            end
         end
         ostt_pkg::CMD_SELECT: begin
            if (up_tag && batch_ff && (!up_hit || own_first)) begin
               dn_hit_in   = 1'b1;
               dn_dl_in    = dl_ff;
               dn_id_in    = id_ff;
               dn_owner_in = owner_ff;
               dn_idle_in  = idle_ff;
               dn_tmo_in   = tmo_ff;
               dn_slot_in  = MY_SLOT;
            end
         end
         ostt_pkg::CMD_FIRE: begin
            if (target_slot == MY_SLOT) begin
               batch_in = 1'b0;
               if (repeat_ff) begin
                  dl_in = step_dl;
               end else begin
                  valid_in = 1'b0;
               end
            end
         end
         ostt_pkg::CMD_ADVANCE: begin
            if (target_slot == MY_SLOT && repeat_ff && due) begin
               dl_in = step_now;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         batch_ff  <= 1'b0;
         dn_tag_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         batch_ff  <= batch_in;
         dn_tag_ff <= dn_tag_in;
      end
      tmo_ff      <= tmo_in;
      id_ff       <= id_in;
      dl_ff       <= dl_in;
      period_ff   <= period_in;
      repeat_ff   <= repeat_in;
      idle_ff     <= idle_in;
      limit_ff    <= limit_in;
      owner_ff    <= owner_in;
      dn_hit_ff   <= dn_hit_in;
      dn_dl_ff    <= dn_dl_in;
      dn_id_ff    <= dn_id_in;
      dn_owner_ff <= dn_owner_in;
      dn_idle_ff  <= dn_idle_in;
      dn_tmo_ff   <= dn_tmo_in;
      dn_slot_ff  <= dn_slot_in;
   end

   assign dn_tag      = dn_tag_ff;
   assign dn_hit      = dn_hit_ff;
   assign dn_deadline = dn_dl_ff;
   assign dn_id       = dn_id_ff;
   assign dn_owner    = dn_owner_ff;
   assign dn_idle     = dn_idle_ff;
   assign dn_tmo      = dn_tmo_ff;
   assign dn_slot     = dn_slot_ff;

endmodule
`default_nettype wire
